// ----- design/qrm_pkg.sv -----
// Package for the quaternion to rotation matrix pipeline.
// Holds widths, entry indexes and the structs passed between stages; no dependencies.
package qrm_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = DATA_WIDTH - 2;
   localparam int PROD_WIDTH = 2 * DATA_WIDTH;
   localparam int NUM_WIDTH  = PROD_WIDTH + 1;
   localparam int REM_WIDTH  = PROD_WIDTH + 2;
   localparam int QUO_WIDTH  = FRAC_BITS + 2;
   localparam int DIV_STAGES = QUO_WIDTH;
   localparam int ENTRIES    = 9;

   localparam int M00 = 0;
   localparam int M01 = 1;
   localparam int M02 = 2;
   localparam int M10 = 3;
   localparam int M11 = 4;
   localparam int M12 = 5;
   localparam int M20 = 6;
   localparam int M21 = 7;
   localparam int M22 = 8;

   localparam logic [ENTRIES-1:0] DIAG_MASK = (ENTRIES'(1) << M00) | (ENTRIES'(1) << M11)
                                            | (ENTRIES'(1) << M22);

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] q_x;
      logic signed [DATA_WIDTH-1:0] q_y;
      logic signed [DATA_WIDTH-1:0] q_z;
      logic signed [DATA_WIDTH-1:0] q_w;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] m00;
      logic signed [DATA_WIDTH-1:0] m01;
      logic signed [DATA_WIDTH-1:0] m02;
      logic signed [DATA_WIDTH-1:0] m10;
      logic signed [DATA_WIDTH-1:0] m11;
      logic signed [DATA_WIDTH-1:0] m12;
      logic signed [DATA_WIDTH-1:0] m20;
      logic signed [DATA_WIDTH-1:0] m21;
      logic signed [DATA_WIDTH-1:0] m22;
   } rsp_type;

   typedef struct packed {
      logic signed [PROD_WIDTH-1:0] xx;
      logic signed [PROD_WIDTH-1:0] yy;
      logic signed [PROD_WIDTH-1:0] zz;
      logic signed [PROD_WIDTH-1:0] ww;
      logic signed [PROD_WIDTH-1:0] xy;
      logic signed [PROD_WIDTH-1:0] xz;
      logic signed [PROD_WIDTH-1:0] yz;
      logic signed [PROD_WIDTH-1:0] xw;
      logic signed [PROD_WIDTH-1:0] yw;
      logic signed [PROD_WIDTH-1:0] zw;
   } prod_type;

   typedef struct packed {
      logic                 neg;
      logic [REM_WIDTH-1:0] rem;
      logic [QUO_WIDTH-1:0] quo;
   } lane_type;

   typedef struct packed {
      logic                 ident;
      logic [NUM_WIDTH-1:0] den;
      lane_type [ENTRIES-1:0] lane;
   } div_type;

endpackage

// ----- design/qrm_mult.sv -----
// Product stage: the ten signed component products of the quaternion.
// Depends on qrm_pkg.
module qrm_mult (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  qrm_pkg::req_type   in_data,
   output logic               out_valid,
   output qrm_pkg::prod_type  out_data
);

   logic               valid_ff;
   qrm_pkg::prod_type  prod_ff;
   qrm_pkg::prod_type  prod_in;

   logic signed [qrm_pkg::PROD_WIDTH-1:0] ext_x;
   logic signed [qrm_pkg::PROD_WIDTH-1:0] ext_y;
   logic signed [qrm_pkg::PROD_WIDTH-1:0] ext_z;
   logic signed [qrm_pkg::PROD_WIDTH-1:0] ext_w;

   always_comb begin
      ext_x = qrm_pkg::PROD_WIDTH'(in_data.q_x);
      ext_y = qrm_pkg::PROD_WIDTH'(in_data.q_y);
      ext_z = qrm_pkg::PROD_WIDTH'(in_data.q_z);
      ext_w = qrm_pkg::PROD_WIDTH'(in_data.q_w);
      prod_in.xx = ext_x * ext_x;
      prod_in.yy = ext_y * ext_y;
      prod_in.zz = ext_z * ext_z;
      prod_in.ww = ext_w * ext_w;
      prod_in.xy = ext_x * ext_y;
      prod_in.xz = ext_x * ext_z;
      prod_in.yz = ext_y * ext_z;
      prod_in.xw = ext_x * ext_w;
      prod_in.yw = ext_y * ext_w;
      prod_in.zw = ext_z * ext_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = prod_ff;

endmodule

// ----- design/qrm_prep.sv -----
// Numerator stages: norm sum, signed entry numerators, then magnitude and sign.
// Depends on qrm_pkg; feeds the first divider stage.
module qrm_prep (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  qrm_pkg::prod_type  in_data,
   output logic               out_valid,
   output qrm_pkg::div_type   out_data
);

   logic                                   sum_valid_ff;
   logic [qrm_pkg::NUM_WIDTH-1:0]          norm_ff;
   logic [qrm_pkg::NUM_WIDTH-1:0]          norm_in;
   logic signed [qrm_pkg::NUM_WIDTH-1:0]   val_ff [qrm_pkg::ENTRIES];
   logic signed [qrm_pkg::NUM_WIDTH-1:0]   val_in [qrm_pkg::ENTRIES];

   logic                                   num_valid_ff;
   qrm_pkg::div_type                       num_ff;
   qrm_pkg::div_type                       num_in;

   logic signed [qrm_pkg::NUM_WIDTH-1:0]   xx, yy, zz, ww, xy, xz, yz, xw, yw, zw;
   logic [qrm_pkg::NUM_WIDTH-1:0]          mag [qrm_pkg::ENTRIES];

   always_comb begin
      xx = qrm_pkg::NUM_WIDTH'(in_data.xx);
      yy = qrm_pkg::NUM_WIDTH'(in_data.yy);
      zz = qrm_pkg::NUM_WIDTH'(in_data.zz);
      ww = qrm_pkg::NUM_WIDTH'(in_data.ww);
      xy = qrm_pkg::NUM_WIDTH'(in_data.xy);
      xz = qrm_pkg::NUM_WIDTH'(in_data.xz);
      yz = qrm_pkg::NUM_WIDTH'(in_data.yz);
      xw = qrm_pkg::NUM_WIDTH'(in_data.xw);
      yw = qrm_pkg::NUM_WIDTH'(in_data.yw);
      zw = qrm_pkg::NUM_WIDTH'(in_data.zw);
      norm_in = (xx + yy) + (zz + ww);
      val_in[qrm_pkg::M00] = (ww + xx) - (yy + zz);
      val_in[qrm_pkg::M01] = xy - zw;
      val_in[qrm_pkg::M02] = xz + yw;
      val_in[qrm_pkg::M10] = xy + zw;
      val_in[qrm_pkg::M11] = (ww + yy) - (xx + zz);
      val_in[qrm_pkg::M12] = yz - xw;
      val_in[qrm_pkg::M20] = xz - yw;
      val_in[qrm_pkg::M21] = yz + xw;
      val_in[qrm_pkg::M22] = (ww + zz) - (xx + yy);
   end

   always_comb begin
      num_in.ident = (norm_ff == '0);
      num_in.den   = norm_ff;
      for (int k = 0; k < qrm_pkg::ENTRIES; k++) begin
         num_in.lane[k].neg = val_ff[k][qrm_pkg::NUM_WIDTH-1];
         mag[k] = val_ff[k][qrm_pkg::NUM_WIDTH-1] ? qrm_pkg::NUM_WIDTH'(-val_ff[k])
                                                  : qrm_pkg::NUM_WIDTH'(val_ff[k]);
         if (qrm_pkg::DIAG_MASK[k]) begin
            num_in.lane[k].rem = qrm_pkg::REM_WIDTH'(mag[k]);
         end else begin
            num_in.lane[k].rem = qrm_pkg::REM_WIDTH'({mag[k][qrm_pkg::NUM_WIDTH-2:0], 1'b0});
         end
         num_in.lane[k].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         num_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= in_valid;
         num_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      norm_ff <= norm_in;
      val_ff  <= val_in;
      num_ff  <= num_in;
   end

   assign out_valid = num_valid_ff;
   assign out_data  = num_ff;

endmodule

// ----- design/qrm_div_stage.sv -----
// One restoring-division step for all nine entries: one quotient bit per lane.
// Depends on qrm_pkg; chained in the top level.
module qrm_div_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  qrm_pkg::div_type  in_data,
   output logic              out_valid,
   output qrm_pkg::div_type  out_data
);

   logic                           valid_ff;
   qrm_pkg::div_type               step_ff;
   qrm_pkg::div_type               step_in;
   logic [qrm_pkg::REM_WIDTH-1:0]  den_ext;
   logic [qrm_pkg::REM_WIDTH-1:0]  diff [qrm_pkg::ENTRIES];
   logic                           fits [qrm_pkg::ENTRIES];

   always_comb begin
      step_in = in_data;
      den_ext = qrm_pkg::REM_WIDTH'(in_data.den);
      for (int k = 0; k < qrm_pkg::ENTRIES; k++) begin
         fits[k] = (in_data.lane[k].rem >= den_ext);
         diff[k] = fits[k] ? (in_data.lane[k].rem - den_ext) : in_data.lane[k].rem;
         step_in.lane[k].rem = {diff[k][qrm_pkg::REM_WIDTH-2:0], 1'b0};
         step_in.lane[k].quo = {in_data.lane[k].quo[qrm_pkg::QUO_WIDTH-2:0], fits[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = step_ff;

endmodule

// ----- design/qrm_round.sv -----
// Output stage: round quotients to nearest, saturate, apply sign, zero-norm identity.
// Depends on qrm_pkg.
module qrm_round (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  qrm_pkg::div_type  in_data,
   output logic              out_valid,
   output qrm_pkg::rsp_type  out_data
);

   localparam logic [qrm_pkg::QUO_WIDTH-1:0] ONE_Q = qrm_pkg::QUO_WIDTH'(1) << qrm_pkg::FRAC_BITS;

   logic                                 valid_ff;
   qrm_pkg::rsp_type                     rsp_ff;
   qrm_pkg::rsp_type                     rsp_in;
   logic [qrm_pkg::QUO_WIDTH:0]          rnd [qrm_pkg::ENTRIES];
   logic [qrm_pkg::QUO_WIDTH-1:0]        mag [qrm_pkg::ENTRIES];
   logic [qrm_pkg::DATA_WIDTH-1:0]       ent [qrm_pkg::ENTRIES];

   always_comb begin
      for (int k = 0; k < qrm_pkg::ENTRIES; k++) begin
         rnd[k] = (qrm_pkg::QUO_WIDTH + 1)'(in_data.lane[k].quo) + 1'b1;
         mag[k] = rnd[k][qrm_pkg::QUO_WIDTH:1];
         if (mag[k] > ONE_Q) begin
            mag[k] = ONE_Q;
         end
         if (in_data.ident) begin
            ent[k] = qrm_pkg::DIAG_MASK[k] ? qrm_pkg::DATA_WIDTH'(ONE_Q) : '0;
         end else if (in_data.lane[k].neg) begin
            ent[k] = qrm_pkg::DATA_WIDTH'(-mag[k]);
         end else begin
            ent[k] = qrm_pkg::DATA_WIDTH'(mag[k]);
         end
      end
      rsp_in.m00 = ent[qrm_pkg::M00];
      rsp_in.m01 = ent[qrm_pkg::M01];
      rsp_in.m02 = ent[qrm_pkg::M02];
      rsp_in.m10 = ent[qrm_pkg::M10];
      rsp_in.m11 = ent[qrm_pkg::M11];
      rsp_in.m12 = ent[qrm_pkg::M12];
      rsp_in.m20 = ent[qrm_pkg::M20];
      rsp_in.m21 = ent[qrm_pkg::M21];
      rsp_in.m22 = ent[qrm_pkg::M22];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

endmodule

// ----- design/quaternion_to_rotation_matrix.sv -----
// Top level: quaternion (Q2.14) to 3x3 rotation matrix (Q2.14, row-major).
// Depends on qrm_pkg, qrm_mult, qrm_prep, qrm_div_stage and qrm_round.
//
//   channel   ports                    transfer when
//   request   start, busy, req_data    start high and busy low at a rising edge
//   response  rsp_strobe, rsp_data     rsp_strobe high at a rising edge
//
// One transfer is taken every cycle; busy stays low.
// The pipeline has one product stage, two numerator stages, 16 division steps
// (one quotient bit per step, set by the restoring divider chain) and one output stage.
// Synchronous reset clears the valid bits of every stage; payload registers are not reset.
// The response side cannot stall, so nothing in the pipeline ever holds.
module quaternion_to_rotation_matrix (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  qrm_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output qrm_pkg::rsp_type  rsp_data
);

   logic               mult_valid;
   qrm_pkg::prod_type  mult_data;
   logic               div_valid [qrm_pkg::DIV_STAGES+1];
   qrm_pkg::div_type   div_data  [qrm_pkg::DIV_STAGES+1];

   assign busy = 1'b0;

   qrm_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_valid (mult_valid),
      .out_data  (mult_data)
   );

   qrm_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mult_valid),
      .in_data   (mult_data),
      .out_valid (div_valid[0]),
      .out_data  (div_data[0])
   );

   for (genvar i = 0; i < qrm_pkg::DIV_STAGES; i++) begin : g_div
      qrm_div_stage u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[i]),
         .in_data   (div_data[i]),
         .out_valid (div_valid[i+1]),
         .out_data  (div_data[i+1])
      );
   end

   qrm_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid[qrm_pkg::DIV_STAGES]),
      .in_data   (div_data[qrm_pkg::DIV_STAGES]),
      .out_valid (rsp_strobe),
      .out_data  (rsp_data)
   );

endmodule
